// ===== hw/rtl/mafrm_pkg.sv =====
// mafrm_pkg: shared types and constants for the frame rate meter
// no dependencies; used by every module under hw/rtl
package mafrm_pkg;

   localparam int unsigned STAMP_W = 64;
   localparam int unsigned WORD_W = 32;
   localparam logic [WORD_W-1:0] TICK_RATE_RESET = 32'd19200000;
   localparam logic [WORD_W-1:0] DELTA_MAX = {WORD_W{1'b1}};

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// ===== hw/rtl/mafrm_div.sv =====
// mafrm_div: restoring divider, one quotient bit per cycle
// depends on mafrm_pkg; divisor is one word wide, dividend is WIDTH bits
module mafrm_div #(
   parameter int unsigned WIDTH = 38
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [WIDTH-1:0]            dividend,
   input  logic [mafrm_pkg::WORD_W-1:0] divisor,
   output logic [WIDTH-1:0]            quotient,
   output mafrm_pkg::div_status_type   status
);
   import mafrm_pkg::*;

   localparam int unsigned CNT_W = $clog2(WIDTH + 1);

   logic [WIDTH-1:0]  quot_ff, quot_in;
   logic [WORD_W-1:0] rem_ff, rem_in;
   logic [WORD_W-1:0] div_ff, div_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [WORD_W:0]   trial;
   logic [WORD_W:0]   trial_diff;
   logic              ge;

   always_comb begin
      trial = {rem_ff, quot_ff[WIDTH-1]};
      trial_diff = trial - {1'b0, div_ff};
      ge = (trial >= {1'b0, div_ff});
      quot_in = quot_ff;
      rem_in = rem_ff;
      div_in = div_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quot_in = dividend;
         rem_in = '0;
         div_in = divisor;
         cnt_in = CNT_W'(WIDTH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quot_in = {quot_ff[WIDTH-2:0], ge};
         rem_in = ge ? trial_diff[WORD_W-1:0] : trial[WORD_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign quotient = quot_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

// ===== hw/rtl/mafrm_ring.sv =====
// mafrm_ring: ring of frame deltas, one write and one registered read port
// depends on mafrm_pkg; entries never written read as zero via valid bits
module mafrm_ring #(
   parameter int unsigned WINDOW = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         rd_en,
   input  logic [$clog2(WINDOW)-1:0]    rd_addr,
   output logic [mafrm_pkg::WORD_W-1:0] rd_data,
   input  logic                         wr_en,
   input  logic [$clog2(WINDOW)-1:0]    wr_addr,
   input  logic [mafrm_pkg::WORD_W-1:0] wr_data
);
   import mafrm_pkg::*;

   logic [WORD_W-1:0] mem [WINDOW];
   logic [WINDOW-1:0] vld_ff;
   logic [WORD_W-1:0] rd_data_ff;
   logic              rd_vld_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_vld_ff <= vld_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_vld_ff ? rd_data_ff : '0;

endmodule

// ===== hw/rtl/moving_average_frame_rate_meter.sv =====
// moving_average_frame_rate_meter: windowed frame period and frame rate from tick stamps
// the first word after reset skips the ring and the divider; each later word updates the ring and sum,
// takes the mean period and then the rate by one pass of the shared divider, skipped when the mean period is zero;
// a WINDOW that is not a power of two adds a further divider pass for the mean period
// one word in work at a time, taken once the previous result sits in the output register;
// synchronous active-high reset clears ring, sum and counters, tick_rate to 19200000
module moving_average_frame_rate_meter #(
   parameter int unsigned WINDOW = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [mafrm_pkg::STAMP_W-1:0] req_timestamp,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [mafrm_pkg::WORD_W-1:0] rsp_frame_period,
   output logic [mafrm_pkg::WORD_W-1:0] rsp_frame_rate,
   output logic [mafrm_pkg::WORD_W-1:0] rsp_frame_number,
   output logic                         rsp_rate_valid,
   input  logic                         csr_write_enable,
   input  logic [mafrm_pkg::WORD_W-1:0] csr_write_data
);
   import mafrm_pkg::*;

   localparam int unsigned IW = $clog2(WINDOW);
   localparam int unsigned SW = WORD_W + IW;
   localparam bit WINDOW_POW2 = ((WINDOW & (WINDOW - 1)) == 0);

   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_SUB       = 3'd1;
   localparam logic [2:0] ST_ADD       = 3'd2;
   localparam logic [2:0] ST_AVG       = 3'd3;
   localparam logic [2:0] ST_AVG_WAIT  = 3'd4;
   localparam logic [2:0] ST_RATE      = 3'd5;
   localparam logic [2:0] ST_RATE_WAIT = 3'd6;
   localparam logic [2:0] ST_DONE      = 3'd7;

   logic [2:0]         state_ff, state_in;
   logic [STAMP_W-1:0] last_stamp_ff, last_stamp_in;
   logic               stamp_seen_ff, stamp_seen_in;
   logic [WORD_W-1:0]  delta_ff, delta_in;
   logic [SW-1:0]      sum_ff, sum_in;
   logic [IW-1:0]      slot_ff, slot_in;
   logic [WORD_W-1:0]  tally_ff, tally_in;
   logic [WORD_W-1:0]  avg_ff, avg_in;
   logic [WORD_W-1:0]  rate_ff, rate_in;
   logic               measured_ff, measured_in;
   logic [WORD_W-1:0]  tick_rate_ff, tick_rate_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]  rsp_tpf_ff, rsp_tpf_in;
   logic [WORD_W-1:0]  rsp_fps_ff, rsp_fps_in;
   logic [WORD_W-1:0]  rsp_num_ff, rsp_num_in;
   logic               rsp_rv_ff, rsp_rv_in;

   logic               req_accept;
   logic [STAMP_W-1:0] stamp_diff;
   logic [WORD_W-1:0]  ring_rd_data;
   logic               ring_wr_en;
   logic               div_start;
   logic [SW-1:0]      div_dividend;
   logic [WORD_W-1:0]  div_divisor;
   logic [SW-1:0]      div_quotient;
   div_status_type     div_sts;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign stamp_diff = req_timestamp - last_stamp_ff;

   mafrm_ring #(
      .WINDOW (WINDOW)
   ) u_ring (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_accept),
      .rd_addr (slot_ff),
      .rd_data (ring_rd_data),
      .wr_en   (ring_wr_en),
      .wr_addr (slot_ff),
      .wr_data (delta_ff)
   );

   mafrm_div #(
      .WIDTH (SW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quotient),
      .status   (div_sts)
   );

   always_comb begin
      state_in = state_ff;
      last_stamp_in = last_stamp_ff;
      stamp_seen_in = stamp_seen_ff;
      delta_in = delta_ff;
      sum_in = sum_ff;
      slot_in = slot_ff;
      tally_in = tally_ff;
      avg_in = avg_ff;
      rate_in = rate_ff;
      measured_in = measured_ff;
      tick_rate_in = csr_write_enable ? csr_write_data : tick_rate_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_tpf_in = rsp_tpf_ff;
      rsp_fps_in = rsp_fps_ff;
      rsp_num_in = rsp_num_ff;
      rsp_rv_in = rsp_rv_ff;
      ring_wr_en = 1'b0;
      div_start = 1'b0;
      div_dividend = sum_ff;
      div_divisor = WORD_W'(WINDOW);

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               last_stamp_in = req_timestamp;
               stamp_seen_in = 1'b1;
               tally_in = tally_ff + 1'b1;
               delta_in = (stamp_diff[STAMP_W-1:WORD_W] != '0) ?
                  DELTA_MAX : stamp_diff[WORD_W-1:0];
               state_in = stamp_seen_ff ? ST_SUB : ST_DONE;
            end
         end
         ST_SUB: begin
            sum_in = sum_ff - {{(SW-WORD_W){1'b0}}, ring_rd_data};
            state_in = ST_ADD;
         end
         ST_ADD: begin
            sum_in = sum_ff + {{(SW-WORD_W){1'b0}}, delta_ff};
            ring_wr_en = 1'b1;
            slot_in = (slot_ff == IW'(WINDOW - 1)) ? '0 : slot_ff + 1'b1;
            state_in = ST_AVG;
         end
         ST_AVG: begin
            if (WINDOW_POW2) begin
               avg_in = sum_ff[IW +: WORD_W];
               state_in = ST_RATE;
            end else begin
               div_start = 1'b1;
               state_in = ST_AVG_WAIT;
            end
         end
         ST_AVG_WAIT: begin
            if (div_sts.done) begin
               avg_in = div_quotient[WORD_W-1:0];
               state_in = ST_RATE;
            end
         end
         ST_RATE: begin
            measured_in = 1'b1;
            if (avg_ff == '0) begin
               rate_in = tick_rate_ff;
               state_in = ST_DONE;
            end else begin
               div_start = 1'b1;
               div_dividend = {{(SW-WORD_W){1'b0}}, tick_rate_ff};
               div_divisor = avg_ff;
               state_in = ST_RATE_WAIT;
            end
         end
         ST_RATE_WAIT: begin
            div_dividend = {{(SW-WORD_W){1'b0}}, tick_rate_ff};
            div_divisor = avg_ff;
            if (div_sts.done) begin
               rate_in = div_quotient[WORD_W-1:0];
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_tpf_in = avg_ff;
               rsp_fps_in = rate_ff;
               rsp_num_in = tally_ff;
               rsp_rv_in = measured_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         last_stamp_ff <= '0;
         stamp_seen_ff <= 1'b0;
         sum_ff <= '0;
         slot_ff <= '0;
         tally_ff <= '0;
         avg_ff <= '0;
         rate_ff <= '0;
         measured_ff <= 1'b0;
         tick_rate_ff <= TICK_RATE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         last_stamp_ff <= last_stamp_in;
         stamp_seen_ff <= stamp_seen_in;
         sum_ff <= sum_in;
         slot_ff <= slot_in;
         tally_ff <= tally_in;
         avg_ff <= avg_in;
         rate_ff <= rate_in;
         measured_ff <= measured_in;
         tick_rate_ff <= tick_rate_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      delta_ff <= delta_in;
      rsp_tpf_ff <= rsp_tpf_in;
      rsp_fps_ff <= rsp_fps_in;
      rsp_num_ff <= rsp_num_in;
      rsp_rv_ff <= rsp_rv_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_frame_period = rsp_tpf_ff;
   assign rsp_frame_rate = rsp_fps_ff;
   assign rsp_frame_number = rsp_num_ff;
   assign rsp_rate_valid = rsp_rv_ff;

   a_div_no_restart: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_sts.busy)
      else $error("divider started while busy");

   a_idle_div_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !div_sts.busy)
      else $error("divider busy with no word in work");

   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      slot_ff <= IW'(WINDOW - 1))
      else $error("ring slot beyond window");

   a_measured_seen: assert property (@(posedge clock) disable iff (reset)
      measured_ff |-> stamp_seen_ff)
      else $error("rate measured without a previous stamp");

endmodule

// ===== verif/moving_average_frame_rate_meter_tb.sv =====
// moving_average_frame_rate_meter_tb: self-checking bench for the frame rate meter
// predicts period, rate, frame count and validity per stamp word, with random idling on both sides
// depends on mafrm_pkg and the moving_average_frame_rate_meter rtl
module moving_average_frame_rate_meter_tb;
   import mafrm_pkg::*;

   localparam int unsigned WINDOW_SIZE = 64;
   localparam int unsigned WORDS_PER_RATE = 145;
   localparam int unsigned HANG_LIMIT = 5000;
   localparam int unsigned RATE_COUNT = 10;

   localparam logic [STAMP_W-1:0] EDGE_STAMPS [20] = '{
      64'hFFFF_FFFF_FFFF_FFF0, 64'h0000_0000_0000_0005, 64'h0000_0000_0000_0005,
      64'h0000_0001_0000_0005, 64'h0000_0002_0000_0004, 64'h0000_0000_0000_0000,
      64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0000,
      64'h8000_0000_0000_0000, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
      64'h5555_5555_5555_5595, 64'h5555_5555_5555_55D5, 64'h5555_5555_5555_5615,
      64'h5555_5555_5555_5655, 64'h5555_5555_5555_5695, 64'h5555_5555_5555_56D5,
      64'h5555_5555_5555_5715, 64'h5555_5555_5555_5755
   };
   localparam logic [WORD_W-1:0] FIXED_RATES [4] = '{
      32'd1, 32'hFFFF_FFFF, 32'd0, TICK_RATE_RESET
   };

   typedef struct packed {
      logic [WORD_W-1:0] frame_period;
      logic [WORD_W-1:0] frame_rate;
      logic [WORD_W-1:0] frame_number;
      logic              rate_valid;
   } rate_reading_type;

   logic                clock;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [STAMP_W-1:0]  req_timestamp = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [WORD_W-1:0]   rsp_frame_period;
   logic [WORD_W-1:0]   rsp_frame_rate;
   logic [WORD_W-1:0]   rsp_frame_number;
   logic                rsp_rate_valid;
   logic                csr_write_enable = 1'b0;
   logic [WORD_W-1:0]   csr_write_data = '0;

   // predictor state
   logic [WORD_W-1:0]   meter_tick_rate = TICK_RATE_RESET;
   logic [STAMP_W-1:0]  prior_stamp = '0;
   logic                prior_seen = 1'b0;
   logic [WORD_W-1:0]   period_ring [WINDOW_SIZE] = '{default: '0};
   logic [39:0]         period_sum = '0;
   int unsigned         oldest_slot = 0;
   logic [WORD_W-1:0]   frame_count = '0;
   logic [WORD_W-1:0]   mean_period = '0;
   logic [WORD_W-1:0]   held_rate = '0;
   logic                rate_known = 1'b0;

   logic [STAMP_W-1:0]  pending_stamps [$];
   rate_reading_type    readings_due [$];
   int unsigned         queued = 0;
   int unsigned         fault_count = 0;
   int unsigned         gap_left = 0;
   int unsigned         stall_left = 0;
   int unsigned         calm_left = 0;
   int unsigned         hang_count = 0;
   logic                calm = 1'b0;

   moving_average_frame_rate_meter #(.WINDOW(WINDOW_SIZE)) dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_timestamp         (req_timestamp),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_frame_period      (rsp_frame_period),
      .rsp_frame_rate        (rsp_frame_rate),
      .rsp_frame_number      (rsp_frame_number),
      .rsp_rate_valid        (rsp_rate_valid),
      .csr_write_enable      (csr_write_enable),
      .csr_write_data        (csr_write_data)
   );

   function automatic rate_reading_type meter_predict(logic [STAMP_W-1:0] stamp);
      logic [STAMP_W-1:0] span;
      logic [WORD_W-1:0]  delta;
      rate_reading_type   reading;
      if (prior_seen) begin
         span = stamp - prior_stamp;
         delta = (span > 64'h0000_0000_FFFF_FFFF) ? DELTA_MAX : span[WORD_W-1:0];
         period_sum = period_sum - period_ring[oldest_slot] + delta;
         period_ring[oldest_slot] = delta;
         oldest_slot = (oldest_slot == WINDOW_SIZE - 1) ? 0 : oldest_slot + 1;
         mean_period = WORD_W'(period_sum / WINDOW_SIZE);
         held_rate = (mean_period == 0) ? meter_tick_rate : meter_tick_rate / mean_period;
         rate_known = 1'b1;
      end
      prior_stamp = stamp;
      prior_seen = 1'b1;
      frame_count = frame_count + 1;
      reading.frame_period = mean_period;
      reading.frame_rate = held_rate;
      reading.frame_number = frame_count;
      reading.rate_valid = rate_known;
      return reading;
   endfunction

   function automatic int unsigned pick_idle();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return $urandom_range(1, 3);
      if (roll < 95) return $urandom_range(4, 20);
      return $urandom_range(40, 200);
   endfunction

   task automatic queue_stamp(input logic [STAMP_W-1:0] stamp);
      pending_stamps.push_back(stamp);
      queued++;
   endtask

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // stretches with no idling on either side
   always @(posedge clock) begin
      if (calm_left != 0) begin
         calm_left--;
      end else begin
         calm_left = $urandom_range(50, 400);
         calm <= ($urandom_range(0, 3) == 0);
      end
   end

   // stamp word driver
   always @(posedge clock) begin
      logic               next_valid;
      logic [STAMP_W-1:0] next_stamp;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         next_valid = req_valid;
         next_stamp = req_timestamp;
         if (req_valid && !req_stall) begin
            readings_due.push_back(meter_predict(req_timestamp));
            next_valid = 1'b0;
         end
         if (!next_valid) begin
            if (gap_left != 0) begin
               gap_left--;
            end else if (pending_stamps.size() != 0) begin
               next_valid = 1'b1;
               next_stamp = pending_stamps.pop_front();
               gap_left = (calm || $urandom_range(0, 9) < 6) ? 0 : pick_idle();
            end
         end
         req_valid <= next_valid;
         req_timestamp <= next_stamp;
      end
   end

   // result word monitor
   always @(posedge clock) begin
      rate_reading_type seen;
      rate_reading_type wanted;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            seen = '{rsp_frame_period, rsp_frame_rate, rsp_frame_number, rsp_rate_valid};
            if (readings_due.size() == 0) begin
               fault_count++;
               if (fault_count <= 10)
                  $display("unexpected word: tpf %0d fps %0d frame %0d valid %b",
                           seen.frame_period, seen.frame_rate,
                           seen.frame_number, seen.rate_valid);
            end else begin
               wanted = readings_due.pop_front();
               if (seen !== wanted) begin
                  fault_count++;
                  if (fault_count <= 10)
                     $display({"frame %0d: expected tpf %0d fps %0d frame %0d valid %b, ",
                               "got tpf %0d fps %0d frame %0d valid %b"},
                              wanted.frame_number, wanted.frame_period,
                              wanted.frame_rate, wanted.frame_number,
                              wanted.rate_valid, seen.frame_period,
                              seen.frame_rate, seen.frame_number, seen.rate_valid);
               end
            end
         end
         if (stall_left != 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            if (!calm && $urandom_range(0, 4) == 0) stall_left = pick_idle();
         end
      end
   end

   // watchdog on cycles with no word moving
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         hang_count = 0;
      end else begin
         hang_count++;
         if (hang_count >= HANG_LIMIT) begin
            $display("moving_average_frame_rate_meter_tb: done, errors");
            $finish;
         end
      end
   end

   initial begin
      logic [WORD_W-1:0] new_rate;
      logic [WORD_W-1:0] period;
      logic [STAMP_W-1:0] stamp_now;
      int unsigned kind;
      int unsigned run_len;
      int unsigned i;
      int unsigned p;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // edge cases at the reset rate
      for (i = 0; i < 20; i++) queue_stamp(EDGE_STAMPS[i]);
      stamp_now = EDGE_STAMPS[19];
      do @(negedge clock);
      while (pending_stamps.size() != 0 || req_valid || readings_due.size() != 0);

      for (p = 0; p < RATE_COUNT; p++) begin
         if (p < 4) new_rate = FIXED_RATES[p];
         else if (p % 2 == 1) new_rate = $urandom;
         else new_rate = $urandom_range(1, 5000);
         @(posedge clock);
         csr_write_enable <= 1'b1;
         csr_write_data <= new_rate;
         @(posedge clock);
         csr_write_enable <= 1'b0;
         meter_tick_rate = new_rate;

         queued = 0;
         while (queued < WORDS_PER_RATE) begin
            kind = $urandom_range(0, 99);
            if (kind < 60) begin
               // steady frames with jitter
               case ($urandom_range(0, 3))
                  0: period = $urandom_range(0, 200);
                  1: period = $urandom_range(1000, 2000000);
                  2: period = $urandom_range(32'h1000_0000, 32'hFFFF_FFFF);
                  default: period = $urandom;
               endcase
               run_len = $urandom_range(10, 80);
               for (i = 0; i < run_len; i++) begin
                  stamp_now = stamp_now + period + $urandom_range(0, period >> 3);
                  queue_stamp(stamp_now);
               end
            end else if (kind < 68) begin
               // stopped counter flushes the window to a zero period
               run_len = $urandom_range(64, 70);
               for (i = 0; i < run_len; i++) queue_stamp(stamp_now);
            end else if (kind < 80) begin
               // run across the counter wrap
               stamp_now = 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 100000);
               period = $urandom_range(1, 20000);
               for (i = 0; i < 8; i++) begin
                  stamp_now = stamp_now + period;
                  queue_stamp(stamp_now);
               end
            end else if (kind < 92) begin
               // long gaps around the saturation point
               run_len = $urandom_range(1, 4);
               for (i = 0; i < run_len; i++) begin
                  case ($urandom_range(0, 3))
                     0: stamp_now = stamp_now + 64'h0000_0000_FFFF_FFFF;
                     1: stamp_now = stamp_now + 64'h0000_0001_0000_0000;
                     2: stamp_now = stamp_now + {30'd0, 2'($urandom_range(0, 3)), 32'($urandom)};
                     default: stamp_now = stamp_now + {32'($urandom), 32'($urandom)};
                  endcase
                  queue_stamp(stamp_now);
               end
            end else begin
               // unrelated stamps
               run_len = $urandom_range(1, 4);
               for (i = 0; i < run_len; i++) begin
                  stamp_now = {32'($urandom), 32'($urandom)};
                  queue_stamp(stamp_now);
               end
            end
         end

         do @(negedge clock);
         while (pending_stamps.size() != 0 || req_valid || readings_due.size() != 0);
      end

      repeat (120) @(posedge clock);
      if (fault_count == 0 && readings_due.size() == 0) begin
         $display("moving_average_frame_rate_meter_tb: done, clean");
      end else begin
         $display("moving_average_frame_rate_meter_tb: done, errors");
      end
      $finish;
   end

endmodule

// ===== moving_average_frame_rate_meter.f =====
hw/rtl/mafrm_pkg.sv
hw/rtl/mafrm_div.sv
hw/rtl/mafrm_ring.sv
hw/rtl/moving_average_frame_rate_meter.sv
verif/moving_average_frame_rate_meter_tb.sv
